FILE: rtl/rpn_pkg.sv
`timescale 1ns / 1ps
package rpn_pkg;
	localparam int DataW = 64;
	localparam int OpW = 3;
	localparam int StatW = 2;
	localparam int DefDepth = 128;

	typedef enum logic [OpW-1:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4,
		OP_END  = 3'd5
	} op_t;

	typedef enum logic [StatW-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_DIVZERO = 2'd3
	} status_t;

	localparam logic [DataW-1:0] MaxPos = {1'b0, {(DataW-1){1'b1}}};
	localparam logic [DataW-1:0] MinNeg = {1'b1, {(DataW-1){1'b0}}};

	// arithmetic unit command
	typedef struct packed {
		logic           start;
		logic [OpW-1:0] op;
	} alu_cmd_t;

	// saturate a sign and magnitude, with an overflow flag
	function automatic logic [DataW-1:0] sat_mag(input logic neg,
			input logic [DataW-1:0] mag, input logic ovf);
		logic [DataW-1:0] r;
		if (neg) begin
			if (ovf || mag > MinNeg) r = MinNeg;
			else r = -mag;
		end else begin
			if (ovf || mag[DataW-1]) r = MaxPos;
			else r = mag;
		end
		return r;
	endfunction
endpackage

FILE: rtl/rpn_stack_calculator.sv
`timescale 1ns / 1ps
// RPN calculator on signed Q32.32. A push is taken every cycle while no
// result waits for the receiver. An end passes through S_EMIT, which loads
// the answer register from the registered stack read; an error found at once
// presents its status the cycle after. Add, subtract, multiply and divide pass
// through operand reads, 64 or 96 steps of the bit-serial arithmetic unit,
// then finish and write-back. One request is processed at a time; a result
// waits in an output register and the next request is taken only once that
// result has been accepted. Stack faults and divide by zero clear the stack
// and report an error status with a zero answer.
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = rpn_pkg::DefDepth
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rpn_pkg::OpW-1:0]       op,
	input  logic signed [rpn_pkg::DataW-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rpn_pkg::StatW-1:0]     status,
	output logic signed [rpn_pkg::DataW-1:0] answer
);
	import rpn_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam logic [DW-1:0] Full = DW'(STACK_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD1  = 6'b000010,
		S_RD2  = 6'b000100,
		S_ALU  = 6'b001000,
		S_WAIT = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t state_q;
	logic [DW-1:0] depth_q;
	logic [OpW-1:0] op_q;
	logic [DataW-1:0] mem [STACK_DEPTH];
	logic [DataW-1:0] rd_q, right_q, left_q;
	logic [AW-1:0] raddr;
	logic we;
	logic [AW-1:0] waddr;
	logic [DataW-1:0] wdata;
	logic out_valid_q;
	logic [StatW-1:0] status_q;
	logic [DataW-1:0] answer_q;
	alu_cmd_t alu_cmd;
	logic alu_done;
	logic [DataW-1:0] alu_res;

	// stack memory
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_comb begin
		raddr = '0;
		if (state_q == S_IDLE) raddr = AW'(depth_q - 1'b1);
		else raddr = AW'(depth_q - 2'd2);
	end

	logic acc;
	assign acc = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && !out_valid_q;

	always_comb begin
		we = 1'b0;
		waddr = AW'(depth_q);
		wdata = value;
		if (acc && op == OP_PUSH && depth_q < Full) we = 1'b1;
		if (state_q == S_WAIT && alu_done) begin
			we = 1'b1;
			waddr = AW'(depth_q - 2'd2);
			wdata = alu_res;
		end
	end

	assign alu_cmd.start = (state_q == S_ALU);
	assign alu_cmd.op = op_q;

	rpn_alu u_alu (
		.clk(clk), .arst_n(arst_n), .cmd(alu_cmd),
		.left(left_q), .right(right_q), .done(alu_done), .result(alu_res)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			out_valid_q <= 1'b0;
			op_q <= '0;
			status_q <= ST_OK;
			answer_q <= '0;
			right_q <= '0;
			left_q <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (acc) begin
					op_q <= op;
					case (op)
						OP_PUSH:
							if (depth_q < Full) depth_q <= depth_q + 1'b1;
							else begin
								depth_q <= '0;
								out_valid_q <= 1'b1;
								status_q <= ST_FULL;
								answer_q <= '0;
							end
						OP_END:
							if (depth_q == '0) begin
								out_valid_q <= 1'b1;
								status_q <= ST_EMPTY;
								answer_q <= '0;
							end else begin
								depth_q <= depth_q - 1'b1;
								state_q <= S_EMIT;
							end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV:
							if (depth_q < 2) begin
								depth_q <= '0;
								out_valid_q <= 1'b1;
								status_q <= ST_EMPTY;
								answer_q <= '0;
							end else state_q <= S_RD1;
						default: ;
					endcase
				end
				S_EMIT: begin
					out_valid_q <= 1'b1;
					status_q <= ST_OK;
					answer_q <= rd_q;
					state_q <= S_IDLE;
				end
				S_RD1: begin
					right_q <= rd_q;
					state_q <= S_RD2;
				end
				S_RD2: begin
					left_q <= rd_q;
					if (op_q == OP_DIV && right_q == '0) begin
						depth_q <= '0;
						out_valid_q <= 1'b1;
						status_q <= ST_DIVZERO;
						answer_q <= '0;
						state_q <= S_IDLE;
					end else state_q <= S_ALU;
				end
				S_ALU: state_q <= S_WAIT;
				S_WAIT: if (alu_done) begin
					depth_q <= depth_q - 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign answer = answer_q;

	// depth never exceeds capacity
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= Full)
		else $error("stack depth overflow");
	// error results carry a zero answer
	a_errz: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> answer_q == '0)
		else $error("error with nonzero answer");
	// no request taken while busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("ready while busy");
endmodule

FILE: rtl/rpn_alu.sv
`timescale 1ns / 1ps
// Bit-serial arithmetic: add/sub one bit per cycle, multiply by shift-add
// one multiplier bit per cycle, divide by restoring division one quotient
// bit per cycle.
module rpn_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rpn_pkg::alu_cmd_t             cmd,
	input  logic [rpn_pkg::DataW-1:0]     left,
	input  logic [rpn_pkg::DataW-1:0]     right,
	output logic                          done,
	output logic [rpn_pkg::DataW-1:0]     result
);
	import rpn_pkg::*;

	localparam int CntW = 7;
	localparam logic [CntW-1:0] AddLen = CntW'(DataW);
	localparam logic [CntW-1:0] MulLen = CntW'(DataW);
	localparam logic [CntW-1:0] DivLen = CntW'(96);

	typedef enum logic [2:0] {
		A_IDLE = 3'b001,
		A_RUN  = 3'b010,
		A_FIN  = 3'b100
	} astate_t;

	astate_t state_q;
	logic [OpW-1:0] op_q;
	logic [CntW-1:0] cnt_q;
	logic neg_q;
	logic [DataW-1:0] a_q, b_q, acc_q;
	logic [DataW:0] hi_q;       // multiply: upper accumulator with carry
	logic ovf_q;
	logic carry_q;
	logic [DataW-1:0] lo_q;     // add/sub result bits, mul low product
	logic [DataW:0] rem_q;
	logic [DataW-1:0] res_q;
	logic done_q;               // res_q holds the finished result

	logic [DataW-1:0] ma, mb;
	assign ma = left[DataW-1] ? -left : left;
	assign mb = right[DataW-1] ? -right : right;

	// serial add bit
	logic bb, sbit, cout;
	assign bb = (op_q == OP_SUB) ? ~b_q[0] : b_q[0];
	assign {cout, sbit} = {1'b0, a_q[0]} + {1'b0, bb} + {1'b0, carry_q};

	// multiply step: add multiplicand if multiplier lsb set, shift right
	logic [DataW:0] msum;
	assign msum = {1'b0, hi_q[DataW-1:0]} + (b_q[0] ? {1'b0, a_q} : '0);

	// divide step
	logic [DataW:0] rsh, rdif;
	assign rsh = {rem_q[DataW-1:0], a_q[DataW-1]};
	assign rdif = rsh - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == A_FIN);
			case (state_q)
				A_IDLE: if (cmd.start) begin
					state_q <= A_RUN;
					cnt_q <= '0;
				end
				A_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if ((op_q == OP_DIV && cnt_q == DivLen - 1'b1) ||
					    (op_q == OP_MUL && cnt_q == MulLen - 1'b1) ||
					    ((op_q == OP_ADD || op_q == OP_SUB) &&
					     cnt_q == AddLen - 1'b1))
						state_q <= A_FIN;
				end
				A_FIN: state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: if (cmd.start) begin
				op_q <= cmd.op;
				neg_q <= left[DataW-1] ^ right[DataW-1];
				ovf_q <= 1'b0;
				hi_q <= '0;
				rem_q <= '0;
				acc_q <= '0;
				carry_q <= (cmd.op == OP_SUB);
				if (cmd.op == OP_ADD || cmd.op == OP_SUB) begin
					a_q <= left;
					b_q <= right;
				end else begin
					a_q <= ma;
					b_q <= mb;
				end
			end
			A_RUN: begin
				case (op_q)
					OP_ADD, OP_SUB: begin
						a_q <= a_q >> 1;
						b_q <= b_q >> 1;
						carry_q <= cout;
						lo_q <= {sbit, lo_q[DataW-1:1]};
					end
					OP_MUL: begin
						b_q <= b_q >> 1;
						hi_q <= {1'b0, msum[DataW:1]};
						lo_q <= {msum[0], lo_q[DataW-1:1]};
					end
					OP_DIV: begin
						// dividend bits then 32 zero bits
						a_q <= a_q << 1;
						if (acc_q[DataW-1]) ovf_q <= 1'b1;
						if (!rdif[DataW]) begin
							rem_q <= rdif;
							acc_q <= {acc_q[DataW-2:0], 1'b1};
						end else begin
							rem_q <= rsh;
							acc_q <= {acc_q[DataW-2:0], 1'b0};
						end
					end
					default: ;
				endcase
			end
			A_FIN: begin
				case (op_q)
					OP_ADD:
						if (left[DataW-1] == right[DataW-1] &&
						    lo_q[DataW-1] != left[DataW-1])
							res_q <= left[DataW-1] ? MinNeg : MaxPos;
						else res_q <= lo_q;
					OP_SUB:
						if (left[DataW-1] != right[DataW-1] &&
						    lo_q[DataW-1] != left[DataW-1])
							res_q <= left[DataW-1] ? MinNeg : MaxPos;
						else res_q <= lo_q;
					OP_MUL:
						res_q <= sat_mag(neg_q, {hi_q[31:0], lo_q[DataW-1:32]},
							hi_q[DataW-1:32] != '0);
					default:
						res_q <= sat_mag(neg_q, acc_q, ovf_q);
				endcase
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result = res_q;

	// idle unit only leaves idle on a start
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == A_IDLE && !cmd.start) |=> state_q == A_IDLE)
		else $error("alu left idle without start");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == A_FIN |=> state_q == A_IDLE)
		else $error("alu finish not single cycle");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == A_RUN |-> cnt_q < DivLen)
		else $error("alu counter overrun");
endmodule

FILE: dv/rpn_stack_calculator_tb.sv
`timescale 1ns / 1ps
module rpn_stack_calculator_tb;
	import rpn_pkg::*;

	localparam int Depth = DefDepth;
	localparam int RandItems = 1190;
	localparam int Drain = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OpW-1:0] op = '0;
	logic signed [DataW-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [StatW-1:0] status;
	logic signed [DataW-1:0] answer;

	typedef struct {
		logic [StatW-1:0] status;
		logic [DataW-1:0] answer;
	} answer_rec_t;

	// directed row; chk set when the expected answer is typed in
	typedef struct {
		logic [OpW-1:0] op;
		logic [DataW-1:0] value;
		bit chk;
		logic [StatW-1:0] status;
		logic [DataW-1:0] answer;
	} row_t;

	answer_rec_t pending_answers[$];
	logic [DataW-1:0] calc_stack[Depth];
	int calc_depth;
	int n_pred;
	int errors;
	int reported;
	bit quiet;
	bit hold_off;
	bit hold_done;

	rpn_stack_calculator #(.STACK_DEPTH(Depth)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .answer(answer)
	);

	always #5 clk = ~clk;

	function automatic logic [DataW-1:0] mag_of(logic [DataW-1:0] x);
		return x[DataW-1] ? -x : x;
	endfunction

	function automatic logic [DataW-1:0] clamp(bit neg, logic [DataW-1:0] m, bit ovf);
		if (neg) return (ovf || m > MinNeg) ? MinNeg : -m;
		return (ovf || m[DataW-1]) ? MaxPos : m;
	endfunction

	function automatic logic [DataW-1:0] q_add(logic [DataW-1:0] a, logic [DataW-1:0] b,
			bit sub);
		logic [DataW-1:0] bb, s;
		bb = sub ? ~b : b;
		s = a + bb + sub;
		if (a[DataW-1] == bb[DataW-1] && s[DataW-1] != a[DataW-1])
			return a[DataW-1] ? MinNeg : MaxPos;
		return s;
	endfunction

	function automatic logic [DataW-1:0] q_mul(logic [DataW-1:0] a, logic [DataW-1:0] b);
		logic [127:0] p;
		p = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
		return clamp(a[DataW-1] ^ b[DataW-1], p[95:32], p[127:96] != 0);
	endfunction

	function automatic logic [DataW-1:0] q_div(logic [DataW-1:0] a, logic [DataW-1:0] b);
		logic [127:0] q;
		q = {32'd0, mag_of(a), 32'd0} / {64'd0, mag_of(b)};
		return clamp(a[DataW-1] ^ b[DataW-1], q[63:0], q[127:64] != 0);
	endfunction

	// advance the calculator state by one request; queue any answer
	task automatic predict_request(logic [OpW-1:0] o, logic [DataW-1:0] v);
		answer_rec_t r;
		logic [DataW-1:0] lhs, rhs, res;
		bit emit;
		emit = 1'b0;
		r.answer = '0;
		r.status = ST_OK;
		case (o)
			OP_PUSH: begin
				if (calc_depth >= Depth) begin
					r.status = ST_FULL; emit = 1'b1; calc_depth = 0;
				end else begin
					calc_stack[calc_depth] = v; calc_depth++;
				end
			end
			OP_END: begin
				emit = 1'b1;
				if (calc_depth == 0) r.status = ST_EMPTY;
				else begin
					calc_depth--; r.answer = calc_stack[calc_depth];
				end
			end
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (calc_depth < 2) begin
					r.status = ST_EMPTY; emit = 1'b1; calc_depth = 0;
				end else begin
					rhs = calc_stack[calc_depth-1];
					lhs = calc_stack[calc_depth-2];
					if (o == OP_DIV && rhs == 0) begin
						r.status = ST_DIVZERO; emit = 1'b1; calc_depth = 0;
					end else begin
						case (o)
							OP_ADD: res = q_add(lhs, rhs, 1'b0);
							OP_SUB: res = q_add(lhs, rhs, 1'b1);
							OP_MUL: res = q_mul(lhs, rhs);
							default: res = q_div(lhs, rhs);
						endcase
						calc_depth--;
						calc_stack[calc_depth-1] = res;
					end
				end
			end
			default: ;
		endcase
		if (emit) begin
			pending_answers.push_back(r);
			n_pred++;
		end
	endtask

	// offer one request and hold it until taken; valid stays up between
	// back-to-back requests and drops only for an idle burst
	task automatic send_request(logic [OpW-1:0] o, logic [DataW-1:0] v);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		value <= v;
		do @(posedge clk); while (!in_ready);
		predict_request(o, v);
	endtask

	function automatic logic [DataW-1:0] rand_value();
		logic [DataW-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = MaxPos;
			1: v = MinNeg;
			2: v = '0;
			3: v = $signed(v) >>> $urandom_range(20, 40);
			4: v = $signed(v) >>> $urandom_range(40, 62);
			default: ;
		endcase
		return v;
	endfunction

	task automatic wait_drained();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		while (n < Drain) begin
			@(posedge clk); n++;
		end
	endtask

	// receiver: random stalls plus one long hold-off
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off && !hold_done) begin
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_done = 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 13);
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// answer checker
	always @(posedge clk) begin
		answer_rec_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("unexpected answer status=%0d answer=%h", status, answer);
				end
			end else begin
				e = pending_answers.pop_front();
				if (e.status !== status || e.answer !== answer) begin
					errors++;
					if (reported < 10) begin
						reported++;
						$display("mismatch: exp status=%0d answer=%h got status=%0d answer=%h",
							e.status, e.answer, status, answer);
					end
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		answer_rec_t tmp;
		int k;
		int n;
		int d;
		logic [OpW-1:0] o;
		errors = 0;
		reported = 0;
		quiet = 1'b0;
		hold_off = 1'b0;
		hold_done = 1'b0;
		calc_depth = 0;
		n_pred = 0;
		// last rows: ignored op codes, then end on an empty stack
		rows = '{
			'{OP_END, 64'd0, 1, ST_EMPTY, 64'd0},
			'{OP_ADD, 64'd0, 1, ST_EMPTY, 64'd0},
			'{OP_PUSH, MaxPos, 0, ST_OK, 64'd0},
			'{OP_END, 64'd0, 1, ST_OK, MaxPos},
			'{OP_PUSH, MinNeg, 0, ST_OK, 64'd0},
			'{OP_END, 64'd0, 1, ST_OK, MinNeg},
			'{OP_PUSH, MaxPos, 0, ST_OK, 64'd0},
			'{OP_PUSH, MaxPos, 0, ST_OK, 64'd0},
			'{OP_ADD, 64'd0, 0, ST_OK, 64'd0},
			'{OP_END, 64'd0, 1, ST_OK, MaxPos},
			'{OP_PUSH, MinNeg, 0, ST_OK, 64'd0},
			'{OP_PUSH, MaxPos, 0, ST_OK, 64'd0},
			'{OP_SUB, 64'd0, 0, ST_OK, 64'd0},
			'{OP_END, 64'd0, 1, ST_OK, MinNeg},
			'{OP_PUSH, 64'h0000_0003_8000_0000, 0, ST_OK, 64'd0},
			'{OP_PUSH, 64'hFFFF_FFFE_0000_0000, 0, ST_OK, 64'd0},
			'{OP_MUL, 64'd0, 0, ST_OK, 64'd0},
			'{OP_PUSH, 64'h0000_0000_0000_0001, 0, ST_OK, 64'd0},
			'{OP_DIV, 64'd0, 0, ST_OK, 64'd0},
			'{OP_END, 64'd0, 0, ST_OK, 64'd0},
			'{OP_PUSH, 64'd5, 0, ST_OK, 64'd0},
			'{OP_PUSH, 64'd0, 0, ST_OK, 64'd0},
			'{OP_DIV, 64'd0, 1, ST_DIVZERO, 64'd0},
			'{3'd6, 64'hFFFF_FFFF_FFFF_FFFF, 0, ST_OK, 64'd0},
			'{3'd7, 64'd0, 0, ST_OK, 64'd0},
			'{OP_END, 64'd0, 1, ST_EMPTY, 64'd0}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			n = n_pred;
			send_request(rows[i].op, rows[i].value);
			if (rows[i].chk) begin
				if (n_pred != n + 1) begin
					errors++;
					$display("table row %0d: model gave no answer", i);
				end else begin
					tmp = pending_answers[$];
					if (tmp.status !== rows[i].status ||
					    tmp.answer !== rows[i].answer) begin
						errors++;
						$display("table row %0d: model disagrees with typed answer", i);
					end
				end
			end
		end

		// fill the stack past full while the receiver holds off
		hold_off = 1'b1;
		for (k = 0; k <= Depth; k++) send_request(OP_PUSH, rand_value());
		send_request(OP_END, 64'd0);
		while (!hold_done) @(posedge clk);
		// sender pauses until everything has come back
		wait_drained();

		// random: mostly well-formed expressions of small depth
		k = 0;
		while (k < RandItems) begin
			if (k > RandItems - 150) quiet = 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				o = OpW'($urandom_range(0, 7));
				send_request(o, rand_value());
				k++;
			end else begin
				d = $urandom_range(1, 5);
				for (int j = 0; j < d; j++) begin
					send_request(OP_PUSH, rand_value()); k++;
				end
				for (int j = 1; j < d; j++) begin
					o = OpW'($urandom_range(OP_ADD, OP_DIV));
					send_request(o, rand_value()); k++;
				end
				send_request(OP_END, rand_value()); k++;
			end
		end
		wait_drained();
		if (errors == 0 && pending_answers.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end
endmodule
